// File: hdl/cfep_pkg.sv
// Shared types and constants of the console field entry parser.
// Depends on nothing; cfep_step and the top level import it.
`default_nettype none

package cfep_pkg;

  // Character set codes held in the charset register.
  localparam logic [2:0] MODE_NONE  = 3'd0;
  localparam logic [2:0] MODE_DEC   = 3'd1;
  localparam logic [2:0] MODE_HEX   = 3'd2;
  localparam logic [2:0] MODE_PRINT = 3'd3;
  localparam logic [2:0] MODE_PHONE = 3'd4;
  localparam logic [2:0] MODE_MAC   = 3'd5;
  localparam logic [2:0] MODE_IP    = 3'd6;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CHARSET  = 2'd0;
  localparam logic [1:0] CFG_EDIT_LEN = 2'd1;
  localparam logic [1:0] CFG_PASSWORD = 2'd2;

  // Result kinds.
  localparam logic [2:0] KIND_ECHO  = 3'd0;
  localparam logic [2:0] KIND_NUM   = 3'd1;
  localparam logic [2:0] KIND_TEXT  = 3'd2;
  localparam logic [2:0] KIND_MAC   = 3'd3;
  localparam logic [2:0] KIND_IP    = 3'd4;
  localparam logic [2:0] KIND_ABORT = 3'd5;

  // Input function codes.
  localparam logic FUNC_START = 1'b0;

  localparam logic [5:0] EDIT_LEN_RST = 6'd16;
  localparam logic [5:0] RUN_MAX      = 6'd63;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic [47:0] value;
  } res_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [5:0] edit_len;
    logic       password;
  } cfg_t;

  // Scalar entry state apart from the position, whose width follows the depth.
  typedef struct packed {
    logic        reading;
    logic [47:0] acc;
    logic [9:0]  oval;
    logic [1:0]  odig;
    logic [2:0]  oidx;
  } ctx_t;

  // What one request produces: a short result list, or a text run.
  typedef struct packed {
    logic [1:0]       cnt;
    res_t [2:0]       items;
    logic             text_run;
    logic [5:0]       run;
    logic             wr_en;
    logic [7:0]       wr_data;
  } act_t;

endpackage

`default_nettype wire

// File: hdl/cfep_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module cfep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/cfep_step.sv
// Per-request decision logic: filters one typed byte, updates the entry state
// and lists the results it causes. Depends on cfep_pkg.
`default_nettype none

module cfep_step
  import cfep_pkg::*;
#(
  parameter int FIELD_DEPTH = 64
) (
  input  wire logic                             func,
  input  wire logic [7:0]                       rx_char,
  input  wire cfg_t                             cfg,
  input  wire ctx_t                             cur,
  input  wire logic [$clog2(FIELD_DEPTH+1)-1:0] pos,
  output ctx_t                                  nxt,
  output logic      [$clog2(FIELD_DEPTH+1)-1:0] pos_nxt,
  output act_t                                  act
);

  localparam int PW = $clog2(FIELD_DEPTH + 1);

  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_ESC  = 8'h1b;
  localparam logic [7:0] CH_DASH = 8'h2d;
  localparam logic [7:0] CH_DOT  = 8'h2e;
  localparam logic [7:0] CH_STAR = 8'h2a;
  localparam logic [7:0] CH_PLUS = 8'h2b;
  localparam logic [7:0] CH_ZERO = 8'h30;

  function automatic res_t mk(input logic [2:0] k, input logic [7:0] b,
                              input logic [47:0] v);
    res_t r;
    r.kind      = k;
    r.data_byte = b;
    r.value     = v;
    return r;
  endfunction

  logic       is_dig, is_uc, is_lc, is_hex, room, ok_text;
  logic [3:0] dval, hval;
  logic [7:0] ch_up;

  always_comb begin
    is_dig = (rx_char inside {[8'h30:8'h39]});
    is_uc  = (rx_char inside {[8'h41:8'h46]});
    is_lc  = (rx_char inside {[8'h61:8'h66]});
    is_hex = is_dig || is_uc || is_lc;
    dval   = rx_char[3:0];
    hval   = is_dig ? rx_char[3:0] : 4'(rx_char[3:0] + 4'd9);
    ch_up  = is_lc ? (rx_char - 8'h20) : rx_char;
    room   = (32'(pos) < 32'(cfg.edit_len)) && (32'(pos) < FIELD_DEPTH);
    ok_text = (cfg.mode == MODE_PRINT) ? (rx_char inside {[8'h20:8'h7e]})
                                       : (is_dig || rx_char == CH_PLUS);
  end

  always_comb begin
    logic [1:0]  n;
    logic [31:0] a32;
    logic [2:0]  dig3;
    logic        done_ip;
    n       = 2'd0;
    a32     = cur.acc[31:0];
    dig3    = 3'd0;
    done_ip = 1'b0;
    nxt     = cur;
    pos_nxt = pos;
    act     = '0;

    if (func == FUNC_START) begin
      nxt     = '0;
      nxt.reading = 1'b1;
      pos_nxt = '0;
    end else if (cur.reading && cfg.mode != MODE_NONE && cfg.mode <= MODE_IP) begin
      if (rx_char == CH_ESC) begin
        act.items[n] = mk(KIND_ABORT, 8'd0, 48'd0);
        n = n + 2'd1;
        nxt.reading = 1'b0;
      end else begin
        case (cfg.mode)
          MODE_DEC, MODE_HEX: begin
            if (rx_char == CH_CR) begin
              act.items[n] = mk(KIND_NUM, 8'd0, {16'd0, a32});
              n = n + 2'd1;
              nxt.reading = 1'b0;
            end else if (room && ((cfg.mode == MODE_DEC) ? is_dig : is_hex)) begin
              if (cfg.mode == MODE_DEC) begin
                a32 = (a32 << 3) + (a32 << 1) + 32'(dval);
              end else begin
                a32 = {a32[27:0], hval};
              end
              nxt.acc      = {16'd0, a32};
              act.wr_en    = 1'b1;
              act.wr_data  = ch_up;
              pos_nxt      = PW'(pos + 1'b1);
              act.items[n] = mk(KIND_ECHO, cfg.password ? CH_STAR : ch_up, 48'd0);
              n = n + 2'd1;
            end
          end
          MODE_PRINT, MODE_PHONE: begin
            if (rx_char == CH_CR) begin
              act.text_run = 1'b1;
              act.run      = (32'(pos) < 32'(RUN_MAX)) ? 6'(pos) : RUN_MAX;
              nxt.reading  = 1'b0;
            end else if (ok_text && room) begin
              act.wr_en    = 1'b1;
              act.wr_data  = rx_char;
              pos_nxt      = PW'(pos + 1'b1);
              act.items[n] = mk(KIND_ECHO, cfg.password ? CH_STAR : rx_char, 48'd0);
              n = n + 2'd1;
            end
          end
          MODE_MAC: begin
            if (is_hex) begin
              act.items[n] = mk(KIND_ECHO, rx_char, 48'd0);
              n = n + 2'd1;
              nxt.acc = {cur.acc[43:0], hval};
              dig3    = {1'b0, cur.odig} + 3'd1;
              nxt.odig = dig3[1:0];
              if (dig3 >= 3'd2) begin
                nxt.odig = 2'd0;
                nxt.oidx = cur.oidx + 3'd1;
                if (nxt.oidx >= 3'd6) begin
                  act.items[n] = mk(KIND_MAC, 8'd0, nxt.acc);
                  n = n + 2'd1;
                  nxt.reading = 1'b0;
                end else begin
                  act.items[n] = mk(KIND_ECHO, CH_DASH, 48'd0);
                  n = n + 2'd1;
                end
              end
            end
          end
          default: begin
            // IP address entry; an octet ends on its third digit or on a dot.
            if (is_dig || rx_char == CH_DOT) begin
              done_ip = 1'b1;
              if (is_dig) begin
                act.items[n] = mk(KIND_ECHO, rx_char, 48'd0);
                n = n + 2'd1;
                nxt.oval = (cur.oval << 3) + (cur.oval << 1) + 10'(dval);
                dig3     = {1'b0, cur.odig} + 3'd1;
                nxt.odig = dig3[1:0];
              end else begin
                if (cur.odig == 2'd0) begin
                  act.items[n] = mk(KIND_ECHO, CH_ZERO, 48'd0);
                  n = n + 2'd1;
                end
                dig3 = 3'd3;
              end
              if (dig3 >= 3'd3) begin
                nxt.acc  = {nxt.acc[39:0], nxt.oval[7:0]};
                nxt.oval = 10'd0;
                nxt.odig = 2'd0;
                if (cur.oidx <= 3'd3) begin
                  act.items[n] = mk(KIND_ECHO, CH_DOT, 48'd0);
                  n = n + 2'd1;
                end
                nxt.oidx = cur.oidx + 3'd1;
              end
            end else if (rx_char == CH_CR) begin
              done_ip = 1'b1;
              if (cur.oidx == 3'd3) begin
                nxt.acc  = {cur.acc[39:0], cur.oval[7:0]};
                nxt.oval = 10'd0;
                nxt.odig = 2'd0;
                nxt.oidx = 3'd4;
              end
            end
            if (done_ip && nxt.oidx >= 3'd4) begin
              act.items[n] = mk(KIND_IP, 8'd0, {16'd0, nxt.acc[31:0]});
              n = n + 2'd1;
              nxt.reading = 1'b0;
            end
          end
        endcase
      end
    end
    act.cnt = n;
  end

endmodule

`default_nettype wire

// File: hdl/console_field_entry_parser.sv
// Top level of the console field entry parser: configuration registers, entry
// state, text store RAM and the result sequencer. Depends on cfep_pkg,
// cfep_ram and cfep_step.
//
//   channel  direction  tuser        tdata                      tlast
//   in_      request    func         rx_char                    -
//   out_     result     kind         data_byte, value           last
//   cfg_     write      -            register index + data      -
//
// A request is taken whenever the sequencer is idle; its results then leave
// one per cycle through the output register while the output is not stalled,
// and no new request is taken meanwhile. A carriage return in printable or
// phone mode walks the text store one character per cycle (run + 1 results).
// Output stalls hold the sequencer; the input is taken again as soon as the
// last result sits in the output register. Reset is synchronous and clears
// control state and the configuration; the text store needs no clearing.
`default_nettype none

module console_field_entry_parser
  import cfep_pkg::*;
#(
  parameter int FIELD_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_char
  input  wire logic [0:0]  in_tuser,   // [0] func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [55:0] out_tdata,  // [7:0] data_byte, [55:8] value
  output logic      [2:0]  out_tuser,  // [2:0] kind
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [5:0]  cfg_wdata
);

  localparam int PW = $clog2(FIELD_DEPTH + 1);
  localparam int AW = $clog2(FIELD_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LIST = 4'b0010,
    ST_TEXT = 4'b0100,
    ST_TERM = 4'b1000
  } seq_t;

  seq_t          seq_r, seq_nxt;
  cfg_t          cfg_r;
  ctx_t          ctx_r, ctx_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  act_t          act;
  res_t [2:0]    list_r;
  logic [1:0]    cnt_r, idx_r, idx_nxt;
  logic [5:0]    run_r, k_r, k_nxt;
  res_t          out_item_r, out_item_nxt;
  logic          out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic          out_free, accept, load;
  logic [7:0]    rd_data;

  assign in_tready  = (seq_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_item_r.value, out_item_r.data_byte};
  assign out_tuser  = out_item_r.kind;
  assign out_tlast  = out_last_r;

  cfep_step #(
    .FIELD_DEPTH(FIELD_DEPTH)
  ) u_step (
    .func    (in_tuser[0]),
    .rx_char (in_tdata),
    .cfg     (cfg_r),
    .cur     (ctx_r),
    .pos     (pos_r),
    .nxt     (ctx_nxt),
    .pos_nxt (pos_nxt),
    .act     (act)
  );

  // The read address follows the next walk index so read data always matches k_r.
  cfep_ram #(
    .WIDTH(8),
    .DEPTH(FIELD_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (accept && act.wr_en),
    .waddr (AW'(pos_r)),
    .wdata (act.wr_data),
    .raddr (AW'(k_nxt)),
    .rdata (rd_data)
  );

  always_comb begin
    seq_nxt       = seq_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    load          = 1'b0;
    out_item_nxt  = out_item_r;
    out_last_nxt  = out_last_r;
    case (seq_r)
      ST_IDLE: begin
        idx_nxt = 2'd0;
        k_nxt   = 6'd0;
        if (accept) begin
          if (act.text_run) begin
            seq_nxt = (act.run == 6'd0) ? ST_TERM : ST_TEXT;
          end else if (act.cnt != 2'd0) begin
            seq_nxt = ST_LIST;
          end
        end
      end
      ST_LIST: begin
        if (out_free) begin
          load         = 1'b1;
          out_item_nxt = list_r[idx_r];
          out_last_nxt = (idx_r == cnt_r - 2'd1);
          idx_nxt      = idx_r + 2'd1;
          if (idx_r == cnt_r - 2'd1) begin
            seq_nxt = ST_IDLE;
          end
        end
      end
      ST_TEXT: begin
        if (out_free) begin
          load         = 1'b1;
          out_item_nxt = '{kind: KIND_TEXT, data_byte: rd_data, value: 48'd0};
          out_last_nxt = 1'b0;
          k_nxt        = k_r + 6'd1;
          if (k_nxt == run_r) begin
            seq_nxt = ST_TERM;
          end
        end
      end
      ST_TERM: begin
        if (out_free) begin
          load         = 1'b1;
          out_item_nxt = '{kind: KIND_TEXT, data_byte: 8'd0, value: 48'd0};
          out_last_nxt = 1'b1;
          seq_nxt      = ST_IDLE;
        end
      end
      default: begin
        seq_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r         <= ST_IDLE;
      cfg_r.mode    <= MODE_NONE;
      cfg_r.edit_len <= EDIT_LEN_RST;
      cfg_r.password <= 1'b0;
      ctx_r         <= '0;
      pos_r         <= '0;
      idx_r         <= 2'd0;
      k_r           <= 6'd0;
      out_valid_r   <= 1'b0;
    end else begin
      seq_r       <= seq_nxt;
      idx_r       <= idx_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        ctx_r <= ctx_nxt;
        pos_r <= pos_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_CHARSET:  cfg_r.mode     <= cfg_wdata[2:0];
          CFG_EDIT_LEN: cfg_r.edit_len <= cfg_wdata;
          CFG_PASSWORD: cfg_r.password <= cfg_wdata[0];
          default:      ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      list_r <= act.items;
      cnt_r  <= act.cnt;
      run_r  <= act.run;
    end
    out_item_r <= out_item_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

`default_nettype wire
